// ===== src/ble_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and table functions of the battery level estimator
// used by every module of the block but ble_div; depends on nothing else

package ble_pkg;

   localparam int DEFAULT_WINDOW = 8;

   localparam int ADC_W   = 12;
   localparam int MV_W    = 12;
   localparam int CELL_W  = 14;
   localparam int PCT_W   = 7;

   // millivolt scaling: raw * MV_SCALE / ADC_FULL, ADC_FULL = 2^ADC_W - 1
   localparam int MV_SCALE = 2500;
   localparam int MV_MAX   = 2500;
   localparam int ADC_FULL = 4095;
   localparam int SCALED_W = 24;

   // cell voltage: mean * 50 / 13 as (mean * CELL_RECIP) >> CELL_SHIFT,
   // CELL_RECIP = ceil(50 * 2^16 / 13), exact for every mean up to MV_MAX
   localparam int CELL_RECIP = 252062;
   localparam int CELL_SHIFT = 16;
   localparam int CELLP_W    = MV_W + 18;

   localparam int LVL_POINTS = 12;
   localparam int LVL_W      = 13;
   localparam int SPAN_W     = 9;
   localparam int DPCT_W     = 4;
   localparam int NUM_W      = SPAN_W + DPCT_W;
   localparam int PCT_FULL   = 100;

   typedef enum logic [1:0] {
      DIV_MEAN,
      DIV_PCT
   } div_sel_type;

   typedef struct packed {
      logic        capture;
      logic        scale;
      logic        update;
      logic        div_start;
      div_sel_type div_sel;
      logic        load_mean;
      logic        load_cell;
      logic        load_seg;
      logic        load_pct;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic interp;
   } status_type;

   typedef struct packed {
      logic [LVL_W-1:0]  lo;
      logic [SPAN_W-1:0] span;
      logic [PCT_W-1:0]  plo;
      logic [DPCT_W-1:0] dpct;
   } seg_type;

   function automatic logic [LVL_W-1:0] lvl_mv(input logic [3:0] idx);
      logic [LVL_W-1:0] r;
      case (idx)
         4'd0:    r = LVL_W'(4200);
         4'd1:    r = LVL_W'(4060);
         4'd2:    r = LVL_W'(3980);
         4'd3:    r = LVL_W'(3920);
         4'd4:    r = LVL_W'(3870);
         4'd5:    r = LVL_W'(3820);
         4'd6:    r = LVL_W'(3790);
         4'd7:    r = LVL_W'(3770);
         4'd8:    r = LVL_W'(3740);
         4'd9:    r = LVL_W'(3680);
         4'd10:   r = LVL_W'(3450);
         4'd11:   r = LVL_W'(3000);
         default: r = LVL_W'(3000);
      endcase
      return r;
   endfunction

   function automatic logic [PCT_W-1:0] lvl_pct(input logic [3:0] idx);
      logic [PCT_W-1:0] r;
      case (idx)
         4'd0:    r = PCT_W'(100);
         4'd1:    r = PCT_W'(90);
         4'd2:    r = PCT_W'(80);
         4'd3:    r = PCT_W'(70);
         4'd4:    r = PCT_W'(60);
         4'd5:    r = PCT_W'(50);
         4'd6:    r = PCT_W'(40);
         4'd7:    r = PCT_W'(30);
         4'd8:    r = PCT_W'(20);
         4'd9:    r = PCT_W'(10);
         4'd10:   r = PCT_W'(5);
         4'd11:   r = PCT_W'(0);
         default: r = PCT_W'(0);
      endcase
      return r;
   endfunction

   // interval of the voltage table holding v, the highest one wins
   function automatic seg_type seg_lookup(input logic [CELL_W-1:0] v);
      seg_type s;
      logic [LVL_W-1:0] hi;
      logic [LVL_W-1:0] lo;
      s = '0;
      for (int k = LVL_POINTS - 2; k >= 0; k--) begin
         hi = lvl_mv(4'(k));
         lo = lvl_mv(4'(k + 1));
         if (v >= CELL_W'(lo)) begin
            s.lo   = lo;
            s.span = SPAN_W'(hi - lo);
            s.plo  = lvl_pct(4'(k + 1));
            s.dpct = DPCT_W'(lvl_pct(4'(k)) - lvl_pct(4'(k + 1)));
         end
      end
      return s;
   endfunction

endpackage

// ===== src/ble_div.sv =====
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
// depends on nothing beyond its parameters

module ble_div #(
   parameter int DVD_W = 17,
   parameter int DVS_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0] shifted;
   logic [DVS_W:0] diff;
   logic           ge;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/ble_dp.sv =====
`timescale 1ns / 1ps
// datapath: millivolt scaling, sample ring with running sum, shared divider,
// table interpolation and the result register; uses ble_pkg and ble_div

module ble_dp #(
   parameter int WINDOW = ble_pkg::DEFAULT_WINDOW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ble_pkg::cmd_type             cmd,
   output ble_pkg::status_type          status,
   input  logic [ble_pkg::ADC_W-1:0]    req_adc_sample,
   output logic [ble_pkg::MV_W-1:0]     rsp_filtered_mv,
   output logic [ble_pkg::CELL_W-1:0]   rsp_battery_mv,
   output logic [ble_pkg::PCT_W-1:0]    rsp_charge_percent,
   output logic                         rsp_percent_valid
);

   localparam int ADC_W    = ble_pkg::ADC_W;
   localparam int MV_W     = ble_pkg::MV_W;
   localparam int CELL_W   = ble_pkg::CELL_W;
   localparam int CELLP_W  = ble_pkg::CELLP_W;
   localparam int PCT_W    = ble_pkg::PCT_W;
   localparam int SCALED_W = ble_pkg::SCALED_W;
   localparam int SPAN_W   = ble_pkg::SPAN_W;
   localparam int NUM_W    = ble_pkg::NUM_W;
   localparam int COUNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int SUM_W    = $clog2(WINDOW * ble_pkg::MV_MAX + 1);
   localparam int DIV_W    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
   localparam int DVS_W    = (COUNT_W > SPAN_W) ? COUNT_W : SPAN_W;

   logic [SCALED_W-1:0] scaled_ff;
   logic [MV_W-1:0]     mv_ff;
   logic [MV_W-1:0]     store_ff [WINDOW];
   logic [SLOT_W-1:0]   slot_ff;
   logic [COUNT_W-1:0]  fill_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [MV_W-1:0]     mean_ff;
   logic [CELL_W-1:0]   cell_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [PCT_W-1:0]    plo_ff;
   logic [PCT_W-1:0]    pct_ff;
   logic [MV_W-1:0]     out_mv_ff;
   logic [CELL_W-1:0]   out_cell_ff;
   logic [PCT_W-1:0]    out_pct_ff;
   logic                out_valid_ff;

   // divide by 2^ADC_W - 1: shift estimate, then one correction step
   logic [SCALED_W-ADC_W-1:0] q_est;
   logic [ADC_W:0]            rem_est;
   logic [MV_W-1:0]           mv_in;

   logic [SUM_W-1:0]    sum_in;
   logic                full;
   logic [CELLP_W-1:0]  cell_prod;
   ble_pkg::seg_type    seg;
   logic [CELL_W-1:0]   cell_off;
   logic [NUM_W-1:0]    num_in;
   logic [PCT_W-1:0]    pct_edge;

   logic [DIV_W-1:0]    div_dividend;
   logic [DVS_W-1:0]    div_divisor;
   logic                div_done;
   logic [DIV_W-1:0]    div_quotient;

   assign q_est   = scaled_ff[SCALED_W-1:ADC_W];
   assign rem_est = {1'b0, scaled_ff[ADC_W-1:0]} + (ADC_W + 1)'(q_est);
   assign mv_in   = MV_W'(q_est) +
                    MV_W'(rem_est >= (ADC_W + 1)'(ble_pkg::ADC_FULL));

   assign sum_in = sum_ff - SUM_W'(store_ff[slot_ff]) + SUM_W'(mv_ff);
   assign full   = fill_ff == COUNT_W'(WINDOW);

   // reciprocal multiply for the fixed divide by 13
   assign cell_prod = CELLP_W'(mean_ff) * CELLP_W'(ble_pkg::CELL_RECIP);

   assign seg      = ble_pkg::seg_lookup(cell_ff);
   assign cell_off = cell_ff - CELL_W'(seg.lo);
   assign num_in   = NUM_W'(cell_off[SPAN_W-1:0]) * NUM_W'(seg.dpct);
   assign pct_edge = (full && cell_ff >= CELL_W'(ble_pkg::lvl_mv(4'd0)))
                     ? PCT_W'(ble_pkg::PCT_FULL) : '0;

   always_comb begin
      case (cmd.div_sel)
         ble_pkg::DIV_MEAN: begin
            div_dividend = DIV_W'(sum_ff);
            div_divisor  = DVS_W'(fill_ff);
         end
         ble_pkg::DIV_PCT: begin
            div_dividend = DIV_W'(num_ff);
            div_divisor  = DVS_W'(span_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = DVS_W'(1);
         end
      endcase
   end

   ble_div #(
      .DVD_W (DIV_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.div_done = div_done;
   assign status.interp   = full &&
                            cell_ff > CELL_W'(ble_pkg::lvl_mv(4'(ble_pkg::LVL_POINTS - 1))) &&
                            cell_ff < CELL_W'(ble_pkg::lvl_mv(4'd0));

   // ring and running sum; unfilled entries read as zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW; k++) begin
            store_ff[k] <= '0;
         end
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.update) begin
         store_ff[slot_ff] <= mv_ff;
         slot_ff <= (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (!full) begin
            fill_ff <= fill_ff + 1'b1;
         end
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         scaled_ff <= SCALED_W'(req_adc_sample) * SCALED_W'(ble_pkg::MV_SCALE);
      end
      if (cmd.scale) begin
         mv_ff <= mv_in;
      end
      if (cmd.load_mean) begin
         mean_ff <= div_quotient[MV_W-1:0];
      end
      if (cmd.load_cell) begin
         cell_ff <= cell_prod[ble_pkg::CELL_SHIFT +: CELL_W];
      end
      if (cmd.load_seg) begin
         num_ff  <= num_in;
         span_ff <= seg.span;
         plo_ff  <= seg.plo;
         pct_ff  <= pct_edge;
      end
      if (cmd.load_pct) begin
         pct_ff <= plo_ff + div_quotient[PCT_W-1:0];
      end
      if (cmd.load_out) begin
         out_mv_ff    <= mean_ff;
         out_cell_ff  <= cell_ff;
         out_pct_ff   <= pct_ff;
         out_valid_ff <= full;
      end
   end

   assign rsp_filtered_mv    = out_mv_ff;
   assign rsp_battery_mv     = out_cell_ff;
   assign rsp_charge_percent = out_pct_ff;
   assign rsp_percent_valid  = out_valid_ff;

endmodule

// ===== src/ble_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences one request through the datapath and owns both
// handshakes; uses ble_pkg for the command and status types

module ble_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ble_pkg::status_type  status,
   output ble_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_UPDATE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_CELL,
      ST_SEG,
      ST_PCT_GO,
      ST_PCT_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = state_ff != ST_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.div_sel  = ble_pkg::DIV_MEAN;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_MEAN_GO;
         end
         ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.load_mean = 1'b1;
               state_in      = ST_CELL;
            end
         end
         ST_CELL: begin
            cmd.load_cell = 1'b1;
            state_in      = ST_SEG;
         end
         ST_SEG: begin
            cmd.load_seg = 1'b1;
            state_in     = status.interp ? ST_PCT_GO : ST_FINISH;
         end
         ST_PCT_GO: begin
            cmd.div_sel   = ble_pkg::DIV_PCT;
            cmd.div_start = 1'b1;
            state_in      = ST_PCT_WAIT;
         end
         ST_PCT_WAIT: begin
            if (status.div_done) begin
               cmd.load_pct = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold here while the previous result is still stalled
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/battery_level_estimator_unit.sv =====
`timescale 1ns / 1ps
// top level of the battery level estimator: controller plus datapath
// uses ble_pkg, ble_ctrl, ble_dp (which holds ble_div)
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_adc_sample
//   rsp      out        rsp_valid/rsp_stall   rsp_filtered_mv, rsp_battery_mv,
//                                             rsp_charge_percent, rsp_percent_valid
//
// one request at a time; the bit-serial divider (DIV_W = 15 at a window of 8), shared by
// the mean and the interpolation, runs for the mean on every request and again for the
// percent when it is interpolated; the cell voltage comes from a reciprocal multiply.
// synchronous reset clears the sample ring, running sum and fill count at once.
// a finished result waits in the output register while the next request is
// taken; that request holds before its result only if the old one is still stalled.

module battery_level_estimator_unit #(
   parameter int WINDOW = ble_pkg::DEFAULT_WINDOW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ble_pkg::ADC_W-1:0]    req_adc_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ble_pkg::MV_W-1:0]     rsp_filtered_mv,
   output logic [ble_pkg::CELL_W-1:0]   rsp_battery_mv,
   output logic [ble_pkg::PCT_W-1:0]    rsp_charge_percent,
   output logic                         rsp_percent_valid
);

   ble_pkg::cmd_type    cmd;
   ble_pkg::status_type status;

   ble_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ble_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_adc_sample     (req_adc_sample),
      .rsp_filtered_mv    (rsp_filtered_mv),
      .rsp_battery_mv     (rsp_battery_mv),
      .rsp_charge_percent (rsp_charge_percent),
      .rsp_percent_valid  (rsp_percent_valid)
   );

endmodule
